// ===== rtl/kslc_pkg.sv =====
// Shared types and constants of the knot state loop counter.
package kslc_pkg;

    localparam int LABEL_W    = 5;
    localparam int NUM_LABELS = 32;
    localparam int CNT_W      = 5;
    localparam int WORD_W     = 16;
    localparam int RES_W      = 6;
    localparam int LOOP_W     = 6;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef logic [LABEL_W-1:0] t_label;

    // Crossing sign as kept per crossing; code 0 means nothing.
    typedef enum logic [1:0] {
        SIGN_NONE = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } t_sign;

    // One stored crossing, already rotated into the L- order.
    typedef struct packed {
        t_label l0;
        t_label l1;
        t_label l2;
        t_label l3;
    } t_row;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_JA1,
        ST_JB1,
        ST_JA2,
        ST_JB2,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        LU_NOP,
        LU_INIT,
        LU_READ,
        LU_MERGE
    } t_lu_op;

    // Command from the sequencer to the loop unit.
    typedef struct packed {
        t_lu_op op;
        t_label lab_a;
        t_label lab_b;
    } t_lu_cmd;

endpackage

// ===== rtl/knot_state_loop_counter.sv =====
// Top level of the knot state loop counter: crossing store, sequencer and result registers.
//
//  Channel   Direction  Handshake                      Carries
//  --------  ---------  -----------------------------  -----------------------------------
//  request   in         start high while busy low      i_func, crossing index, labels, word
//  result    out        o_result_valid, one cycle      exponent, loop total, writhe
//  config    in         i_cfg_wr_en, no wait           crossing count
//
// A load request never raises busy; it produces no result.
// An evaluate request holds busy up to its result (n the effective crossing count):
// each crossing takes two joins in the shared loop unit, a read step and a merge step
// each, and the result strobe follows in the cycle after the last merge.
// With n equal to zero the result appears in the cycle after the request.
// Reset is synchronous and active low; it sets the count to one and clears all signs.
// The receiver cannot stall: each result is shown for exactly one cycle.
module knot_state_loop_counter #(
    parameter int MAX_CROSSINGS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_func,
    input  logic [3:0]                         i_crossing_index,
    input  logic [kslc_pkg::LABEL_W-1:0]       i_label_a,
    input  logic [kslc_pkg::LABEL_W-1:0]       i_label_b,
    input  logic [kslc_pkg::LABEL_W-1:0]       i_label_c,
    input  logic [kslc_pkg::LABEL_W-1:0]       i_label_d,
    input  logic [kslc_pkg::WORD_W-1:0]        i_state_word,
    input  logic                               i_cfg_wr_en,
    input  logic [kslc_pkg::CNT_W-1:0]         i_cfg_wr_data,
    output logic                               o_result_valid,
    output logic signed [kslc_pkg::RES_W-1:0]  o_smooth_exponent,
    output logic [kslc_pkg::LABEL_W-1:0]       o_loop_total,
    output logic signed [kslc_pkg::RES_W-1:0]  o_writhe
);

    localparam int IDX_W = (MAX_CROSSINGS > 1) ? $clog2(MAX_CROSSINGS) : 1;
    localparam int CW    = kslc_pkg::CNT_W;
    localparam int RW    = kslc_pkg::RES_W;
    localparam logic [CW:0] MAX_N = (CW + 1)'(MAX_CROSSINGS);

    // Configuration: number of crossings, clipped to the store depth when used.
    logic [CW-1:0] r_cfg_count;
    logic [CW-1:0] n_eff;

    // Crossing store: one row of four rotated labels per crossing, plus its sign.
    kslc_pkg::t_row  r_row_mem [MAX_CROSSINGS];
    kslc_pkg::t_row  r_row;
    kslc_pkg::t_sign r_sign [MAX_CROSSINGS];

    // Sequencer registers.
    kslc_pkg::t_state              r_state;
    kslc_pkg::t_state              n_state;
    logic [CW-1:0]                 r_k;
    logic [CW-1:0]                 n_k;
    logic [kslc_pkg::WORD_W-1:0]   r_word;
    logic [kslc_pkg::WORD_W-1:0]   n_word;
    logic signed [RW-1:0]          r_expo;
    logic signed [RW-1:0]          n_expo;
    logic signed [RW-1:0]          r_wr;
    logic signed [RW-1:0]          n_wr;

    kslc_pkg::t_lu_cmd lu_cmd;

    // Load path signals.
    logic             accept;
    logic             load_en;
    logic             idx_ok;
    logic             last_xing;
    logic             rotate;
    logic [CW:0]      two_n;
    kslc_pkg::t_sign  ld_sign;
    kslc_pkg::t_row   ld_row;
    logic [IDX_W-1:0] wr_idx;

    // Evaluate path signals.
    logic             smooth_inv;
    logic             first_join;
    kslc_pkg::t_sign  cur_sign;

    assign n_eff = ({1'b0, r_cfg_count} > MAX_N) ? MAX_N[CW-1:0] : r_cfg_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= CW'(1);
        end else if (i_cfg_wr_en) begin
            r_cfg_count <= i_cfg_wr_data;
        end
    end

    assign busy   = (r_state != kslc_pkg::ST_IDLE);
    assign accept = start && !busy;

    // ---------------------------------------------------------------------
    // Load: classify the crossing and rotate it into the L- order. The last
    // crossing rotates the other way round. Equal labels b and d give no sign.
    // ---------------------------------------------------------------------
    assign two_n     = {n_eff, 1'b0};
    assign idx_ok    = ({{(CW - 3){1'b0}}, i_crossing_index} < MAX_N);
    assign last_xing = (n_eff != '0) && ({1'b0, i_crossing_index} == n_eff - CW'(1));
    assign load_en   = accept && (i_func == kslc_pkg::FUNC_LOAD) && idx_ok;
    assign wr_idx    = IDX_W'(i_crossing_index);

    always_comb begin
        ld_sign = kslc_pkg::SIGN_NONE;
        rotate  = 1'b0;
        if (i_label_b > i_label_d) begin
            // Wrap-around at the highest segment back to zero reverses the sense.
            ld_sign = ((n_eff != '0) && ({1'b0, i_label_b} == two_n - (CW + 1)'(1))
                       && (i_label_d == '0)) ? kslc_pkg::SIGN_NEG : kslc_pkg::SIGN_POS;
            rotate  = !last_xing;
        end else if (i_label_b < i_label_d) begin
            ld_sign = ((n_eff != '0) && ({1'b0, i_label_d} == two_n - (CW + 1)'(1))
                       && (i_label_b == '0)) ? kslc_pkg::SIGN_POS : kslc_pkg::SIGN_NEG;
            rotate  = last_xing;
        end
        if (rotate) begin
            ld_row = '{l0: i_label_d, l1: i_label_a, l2: i_label_b, l3: i_label_c};
        end else begin
            ld_row = '{l0: i_label_a, l1: i_label_b, l2: i_label_c, l3: i_label_d};
        end
    end

    // Label rows sit in a plain memory: one write port for loads and one
    // registered read port addressed by the next crossing number, so that
    // the row is ready in the first cycle of each crossing.
    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_row_mem[wr_idx] <= ld_row;
        end
        r_row <= r_row_mem[n_k[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CROSSINGS; i++) begin
                r_sign[i] <= kslc_pkg::SIGN_NONE;
            end
        end else if (load_en) begin
            r_sign[wr_idx] <= ld_sign;
        end
    end

    // ---------------------------------------------------------------------
    // Evaluate: per crossing two joins, each a read step and a merge step.
    // Smoothing A pairs (l0,l1) and (l2,l3); the inverse pairs (l0,l3) and
    // (l2,l1). State bits above the word width read as A.
    // ---------------------------------------------------------------------
    assign smooth_inv = !r_k[CW-1] && r_word[r_k[CW-2:0]];
    assign first_join = (r_state == kslc_pkg::ST_JA1) || (r_state == kslc_pkg::ST_JB1);
    assign cur_sign   = r_sign[r_k[IDX_W-1:0]];

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_word       = r_word;
        n_expo       = r_expo;
        n_wr         = r_wr;
        lu_cmd.op    = kslc_pkg::LU_NOP;
        lu_cmd.lab_a = first_join ? r_row.l0 : r_row.l2;
        if (first_join) begin
            lu_cmd.lab_b = smooth_inv ? r_row.l3 : r_row.l1;
        end else begin
            lu_cmd.lab_b = smooth_inv ? r_row.l1 : r_row.l3;
        end

        unique case (r_state)
            kslc_pkg::ST_IDLE: begin
                if (start && (i_func == kslc_pkg::FUNC_EVAL)) begin
                    lu_cmd.op = kslc_pkg::LU_INIT;
                    n_k       = '0;
                    n_word    = i_state_word;
                    n_expo    = '0;
                    n_wr      = '0;
                    n_state   = (n_eff == '0) ? kslc_pkg::ST_DONE : kslc_pkg::ST_JA1;
                end
            end
            kslc_pkg::ST_JA1: begin
                lu_cmd.op = kslc_pkg::LU_READ;
                n_state   = kslc_pkg::ST_JB1;
            end
            kslc_pkg::ST_JB1: begin
                lu_cmd.op = kslc_pkg::LU_MERGE;
                n_state   = kslc_pkg::ST_JA2;
            end
            kslc_pkg::ST_JA2: begin
                lu_cmd.op = kslc_pkg::LU_READ;
                n_state   = kslc_pkg::ST_JB2;
            end
            kslc_pkg::ST_JB2: begin
                lu_cmd.op = kslc_pkg::LU_MERGE;
                n_expo    = smooth_inv ? (r_expo - RW'(1)) : (r_expo + RW'(1));
                case (cur_sign)
                    kslc_pkg::SIGN_POS: n_wr = r_wr + RW'(1);
                    kslc_pkg::SIGN_NEG: n_wr = r_wr - RW'(1);
                    default:            n_wr = r_wr;
                endcase
                n_k     = r_k + CW'(1);
                n_state = (n_k == n_eff) ? kslc_pkg::ST_DONE : kslc_pkg::ST_JA1;
            end
            kslc_pkg::ST_DONE: begin
                n_state = kslc_pkg::ST_IDLE;
            end
            default: begin
                n_state = kslc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kslc_pkg::ST_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_expo <= n_expo;
        r_wr   <= n_wr;
    end

    kslc_loop_unit u_loop_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (lu_cmd),
        .o_loops (o_loop_total)
    );

    assign o_result_valid    = (r_state == kslc_pkg::ST_DONE);
    assign o_smooth_exponent = r_expo;
    assign o_writhe          = r_wr;

`ifndef SYNTHESIS
    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == kslc_pkg::FUNC_EVAL) |=> busy)
        else $error("evaluate request did not raise busy");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == kslc_pkg::FUNC_LOAD) |=> (!busy && !o_result_valid))
        else $error("load request started work or produced a result");
`endif

endmodule

// ===== rtl/kslc_loop_unit.sv =====
// Component tracker: joins label pairs and keeps a running count of closed loops.
module kslc_loop_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kslc_pkg::t_lu_cmd               i_cmd,
    output logic [kslc_pkg::LABEL_W-1:0]    o_loops
);

    localparam int NL = kslc_pkg::NUM_LABELS;
    localparam int LW = kslc_pkg::LABEL_W;
    localparam int CW = kslc_pkg::LOOP_W;

    // Component id of each label; ids are the smallest member label.
    logic [LW-1:0] r_comp [NL];
    logic [LW-1:0] r_ca;
    logic [NL-1:0] r_visited;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic [LW-1:0] rd_addr;
    logic [LW-1:0] rd_val;
    logic [LW-1:0] hi_id;
    logic [LW-1:0] lo_id;
    logic          new_a;
    logic          new_b;
    logic          merged;
    logic [NL-1:0] bit_a;
    logic [NL-1:0] bit_b;

    // Single read port: label a in the read step, label b in the merge step.
    assign rd_addr = (i_cmd.op == kslc_pkg::LU_READ) ? i_cmd.lab_a : i_cmd.lab_b;
    assign rd_val  = r_comp[rd_addr];

    assign merged = (r_ca != rd_val);
    assign hi_id  = (r_ca > rd_val) ? r_ca : rd_val;
    assign lo_id  = (r_ca > rd_val) ? rd_val : r_ca;

    assign new_a  = !r_visited[i_cmd.lab_a];
    assign new_b  = !r_visited[i_cmd.lab_b] && (i_cmd.lab_b != i_cmd.lab_a);
    assign bit_a  = {{(NL-1){1'b0}}, 1'b1} << i_cmd.lab_a;
    assign bit_b  = {{(NL-1){1'b0}}, 1'b1} << i_cmd.lab_b;

    assign n_count = r_count + {{(CW-1){1'b0}}, new_a} + {{(CW-1){1'b0}}, new_b}
                   - {{(CW-1){1'b0}}, merged};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
            r_count   <= '0;
        end else begin
            unique case (i_cmd.op)
                kslc_pkg::LU_INIT: begin
                    r_visited <= '0;
                    r_count   <= '0;
                end
                kslc_pkg::LU_MERGE: begin
                    r_visited <= r_visited | bit_a | bit_b;
                    r_count   <= n_count;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            kslc_pkg::LU_INIT: begin
                for (int i = 0; i < NL; i++) begin
                    r_comp[i] <= LW'(i);
                end
            end
            kslc_pkg::LU_READ: begin
                r_ca <= rd_val;
            end
            kslc_pkg::LU_MERGE: begin
                for (int i = 0; i < NL; i++) begin
                    if (r_comp[i] == hi_id) begin
                        r_comp[i] <= lo_id;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // The count can reach 32 only with every label a loop of its own.
    assign o_loops = r_count[CW-1] ? {LW{1'b1}} : r_count[LW-1:0];

endmodule
